/* rtl/pgalloc_pkg.sv */
// shared types and codes for the page allocator
package pgalloc_pkg;

    // command codes on the input beat; codes six and seven are unused
    typedef enum logic [2:0] {
        CMD_SEED  = 3'd0,
        CMD_ALLOC = 3'd1,
        CMD_FREE  = 3'd2,
        CMD_INC   = 3'd3,
        CMD_DEC   = 3'd4,
        CMD_READ  = 3'd5
    } t_cmd;

    // status codes on the result beat
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_BAD_REF = 2'd3
    } t_status;

    // fixed port widths
    localparam int PAGE_W       = 16;
    localparam int FIRST_PAGE_W = 14;
    localparam int ALLOC_PAGE_W = 14;
    localparam int REF_COUNT_W  = 8;
    localparam int FREE_COUNT_W = 15;

    // what the update logic needs to know about the command in flight
    typedef struct packed {
        t_cmd cmd;
        logic in_range;
        logic empty;
        logic full;
    } t_upd_req;

    // what the update logic decides
    typedef struct packed {
        t_status status;
        logic    rc_we;
        logic    push;
        logic    pop;
    } t_upd_res;

endpackage

/* rtl/pgalloc_ram.sv */
// generic single-port-write, single-port-read ram with registered read
module pgalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/pgalloc_update.sv */
// command decode and reference count update for one command
module pgalloc_update #(
    parameter int REF_BITS = 8
) (
    input  pgalloc_pkg::t_upd_req i_req,
    input  logic [REF_BITS-1:0]   i_cnt_old,
    output pgalloc_pkg::t_upd_res o_res,
    output logic [REF_BITS-1:0]   o_cnt_new
);

    localparam logic [REF_BITS-1:0] REF_MAX = '1;
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);

    always_comb begin
        o_res.status = pgalloc_pkg::ST_OK;
        o_res.rc_we  = 1'b0;
        o_res.push   = 1'b0;
        o_res.pop    = 1'b0;
        o_cnt_new    = '0;
        unique case (i_req.cmd) inside
            pgalloc_pkg::CMD_ALLOC: begin
                if (i_req.empty) begin
                    o_res.status = pgalloc_pkg::ST_NO_FREE;
                end else begin
                    o_res.pop   = 1'b1;
                    o_res.rc_we = 1'b1;
                    o_cnt_new   = REF_ONE;
                end
            end
            pgalloc_pkg::CMD_SEED, pgalloc_pkg::CMD_FREE, pgalloc_pkg::CMD_INC,
            pgalloc_pkg::CMD_DEC, pgalloc_pkg::CMD_READ: begin
                if (!i_req.in_range) begin
                    o_res.status = pgalloc_pkg::ST_RANGE;
                end else begin
                    o_res.rc_we = 1'b1;
                    o_cnt_new   = i_cnt_old;
                    unique case (i_req.cmd)
                        pgalloc_pkg::CMD_SEED: begin
                            // seeding skips the count check
                            if (!i_req.full) begin
                                o_res.push = 1'b1;
                                o_cnt_new  = '0;
                            end
                        end
                        pgalloc_pkg::CMD_FREE: begin
                            if (i_cnt_old != REF_ONE) begin
                                o_res.status = pgalloc_pkg::ST_BAD_REF;
                            end else if (!i_req.full) begin
                                o_res.push = 1'b1;
                                o_cnt_new  = '0;
                            end
                        end
                        pgalloc_pkg::CMD_INC: begin
                            if (i_cnt_old != REF_MAX) begin
                                o_cnt_new = i_cnt_old + REF_ONE;
                            end
                        end
                        pgalloc_pkg::CMD_DEC: begin
                            if (i_cnt_old == '0) begin
                                o_res.status = pgalloc_pkg::ST_BAD_REF;
                            end else begin
                                o_cnt_new = i_cnt_old - REF_ONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                // unused codes do nothing
            end
        endcase
    end

endmodule

/* rtl/page_allocator_with_refcounts.sv */
// physical page allocator top level: free page stack and reference counts
//
// Physical page allocator. A last-in-first-out stack of free page numbers
// and a reference count per page live in two synchronous rams; the stack
// depth is a register. Each command beat is handled in a read step and an
// update step: the accept cycle issues the ram read (the stack top for
// allocate, the page's count for every other command in range), the
// update step then updates the count, writes it back, pushes or pops the
// stack and loads the result register. A result that is stalled holds
// the update step until it leaves, but the next command is taken as soon
// as the update step is done. After reset the block sweeps the count ram
// to zero, one entry a cycle, and accepts no command beat before the
// sweep is done.
// first_page may be written at any time and is meant to change only when
// the block is idle.
module page_allocator_with_refcounts #(
    parameter int PAGES    = 16384,
    parameter int REF_BITS = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration
    input  logic                                   i_cfg_we,
    input  logic [pgalloc_pkg::FIRST_PAGE_W-1:0]   i_cfg_data,
    // command channel
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [2:0]                             i_command,
    input  logic [pgalloc_pkg::PAGE_W-1:0]         i_page,
    // result channel
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [1:0]                             o_status,
    output logic [pgalloc_pkg::ALLOC_PAGE_W-1:0]   o_alloc_page,
    output logic [pgalloc_pkg::REF_COUNT_W-1:0]    o_ref_count,
    output logic [pgalloc_pkg::FREE_COUNT_W-1:0]   o_free_count
);

    // page index width and stack depth width (depth can reach PAGES)
    localparam int AW = $clog2(PAGES);
    localparam int DW = $clog2(PAGES + 1);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(PAGES);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(PAGES - 1);
    localparam logic [pgalloc_pkg::PAGE_W:0] PAGE_LIMIT =
        (pgalloc_pkg::PAGE_W + 1)'(PAGES);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                                r_state;
    logic [AW-1:0]                         r_clr_addr;
    logic [DW-1:0]                         r_depth;
    logic [DW-1:0]                         n_depth;
    logic [pgalloc_pkg::FIRST_PAGE_W-1:0]  r_first_page;

    // command held between the read and the update step
    pgalloc_pkg::t_cmd                     r_cmd;
    logic [AW-1:0]                         r_pg;
    logic                                  r_in_range;

    // result register
    logic                                  r_out_valid;
    pgalloc_pkg::t_status                  r_status;
    logic [pgalloc_pkg::ALLOC_PAGE_W-1:0]  r_alloc_page;
    logic [pgalloc_pkg::REF_COUNT_W-1:0]   r_ref_count;
    logic [pgalloc_pkg::FREE_COUNT_W-1:0]  r_free_count;

    logic                  in_accept;
    logic                  in_range;
    logic                  stack_empty;
    logic                  stack_full;
    logic [DW-1:0]         depth_m1;
    logic                  exec_fire;
    logic                  clearing;

    logic                  stk_we;
    logic                  stk_re;
    logic [AW-1:0]         stk_raddr;
    logic [AW-1:0]         stk_rdata;

    logic                  rc_we;
    logic [AW-1:0]         rc_waddr;
    logic [REF_BITS-1:0]   rc_wdata;
    logic                  rc_re;
    logic [REF_BITS-1:0]   rc_rdata;

    pgalloc_pkg::t_upd_req upd_req;
    pgalloc_pkg::t_upd_res upd_res;
    logic [REF_BITS-1:0]   cnt_new;

    // the command port is open only in idle; the result register is free
    // on its own, so a waiting result does not block the accept
    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // a page is managed when first_page <= page < PAGES
    assign in_range = (i_page >= pgalloc_pkg::PAGE_W'(r_first_page)) &&
                      ({1'b0, i_page} < PAGE_LIMIT);

    assign stack_empty = (r_depth == '0);
    assign stack_full  = (r_depth == DEPTH_FULL);
    assign depth_m1    = r_depth - DW'(1);

    // update step waits while an older result still sits in the register
    assign exec_fire = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);
    assign clearing  = (r_state == S_CLEAR);

    // stack: pop reads the top in the accept cycle, push writes at depth
    assign stk_re    = in_accept &&
                       (pgalloc_pkg::t_cmd'(i_command) == pgalloc_pkg::CMD_ALLOC) &&
                       !stack_empty;
    assign stk_raddr = depth_m1[AW-1:0];
    assign stk_we    = exec_fire && upd_res.push;

    // counts: read the addressed page, write back in the update step;
    // allocate writes the popped page, the sweep writes zeros
    assign rc_re    = in_accept && in_range &&
                      (pgalloc_pkg::t_cmd'(i_command) != pgalloc_pkg::CMD_ALLOC);
    assign rc_we    = clearing || (exec_fire && upd_res.rc_we);
    assign rc_waddr = clearing ? r_clr_addr :
                      (upd_res.pop ? stk_rdata : r_pg);
    assign rc_wdata = clearing ? '0 : cnt_new;

    pgalloc_ram #(
        .WIDTH (AW),
        .DEPTH (PAGES)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (r_depth[AW-1:0]),
        .i_wdata (r_pg),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    pgalloc_ram #(
        .WIDTH (REF_BITS),
        .DEPTH (PAGES)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (rc_we),
        .i_waddr (rc_waddr),
        .i_wdata (rc_wdata),
        .i_re    (rc_re),
        .i_raddr (i_page[AW-1:0]),
        .o_rdata (rc_rdata)
    );

    assign upd_req.cmd      = r_cmd;
    assign upd_req.in_range = r_in_range;
    assign upd_req.empty    = stack_empty;
    assign upd_req.full     = stack_full;

    pgalloc_update #(
        .REF_BITS (REF_BITS)
    ) u_update (
        .i_req     (upd_req),
        .i_cnt_old (rc_rdata),
        .o_res     (upd_res),
        .o_cnt_new (cnt_new)
    );

    // stack depth after the command in the update step
    always_comb begin
        n_depth = r_depth;
        if (upd_res.push) begin
            n_depth = r_depth + DW'(1);
        end else if (upd_res.pop) begin
            n_depth = depth_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_depth      <= '0;
            r_first_page <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_first_page <= i_cfg_data;
            end

            // a new result replaces the one leaving in the same cycle
            if (exec_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    // zero sweep of the count ram
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_accept) begin
                        r_cmd      <= pgalloc_pkg::t_cmd'(i_command);
                        r_pg       <= i_page[AW-1:0];
                        r_in_range <= in_range;
                        r_state    <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_fire) begin
                        r_depth      <= n_depth;
                        r_status     <= upd_res.status;
                        r_alloc_page <= upd_res.pop ?
                                        pgalloc_pkg::ALLOC_PAGE_W'(stk_rdata) : '0;
                        r_ref_count  <= pgalloc_pkg::REF_COUNT_W'(cnt_new);
                        r_free_count <= pgalloc_pkg::FREE_COUNT_W'(n_depth);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_alloc_page = r_alloc_page;
    assign o_ref_count  = r_ref_count;
    assign o_free_count = r_free_count;

endmodule
